// File: rtl/core/ddb_pkg.sv
// ddb_pkg: shared types and constants for the duct damper balance step unit.
// Used by the top level, the iterative divider and the port checker.
`default_nettype none

package ddb_pkg;

    localparam int TEMP_W   = 14;
    localparam int OPEN_W   = 15;
    localparam int ANGLE_W  = 8;
    localparam int MAG_W    = 12;
    localparam int DIVD_W   = 28;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [OPEN_W-1:0]        open_t;
    typedef logic [ANGLE_W-1:0]       angle_t;
    typedef logic [MAG_W-1:0]         mag_t;

    typedef enum logic [1:0] {
        STATUS_ADJUSTED = 2'd0,
        STATUS_MANUAL   = 2'd1,
        STATUS_EQUAL    = 2'd2,
        STATUS_MISSING  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 2'd0,
        REG_TARGET      = 2'd1,
        REG_MAN_INSIDE  = 2'd2,
        REG_MAN_OUTSIDE = 2'd3
    } cfg_idx_t;

    localparam open_t        FULL_OPEN     = 15'd25600;
    localparam mag_t         BIG_MOVE      = 12'd1280;
    localparam logic [13:0]  MOVE_SCALE    = 14'd12800;
    localparam logic [6:0]   SMALL_FACTOR  = 7'd100;
    localparam logic [2:0]   BIG_FACTOR    = 3'd5;
    localparam temp_t        TARGET_RESET  = 14'sd320;
    localparam logic [7:0]   IN_SPAN       = 8'd165;
    localparam angle_t       IN_BASE       = 8'd15;
    localparam angle_t       OUT_SPAN      = 8'd180;
    localparam logic [14:0]  CEIL_BIAS     = 15'd25599;
    localparam logic [12:0]  RECIP_100     = 13'd5243;
    localparam int           RECIP_SHIFT   = 19;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [TEMP_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        mag_t                quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/ddb_div.sv
// ddb_div: restoring divider, one quotient bit per cycle.
// Needs dividend < divisor * 2^12. Depends on ddb_pkg.
`default_nettype none

module ddb_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ddb_pkg::div_req_t req,
    output ddb_pkg::div_rsp_t      rsp
);
    import ddb_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TEMP_W-1:0] rem_reg, rem_next;
    logic [TEMP_W-1:0] den_reg, den_next;
    mag_t              quot_reg, quot_next;

    logic [TEMP_W:0]   trial;
    logic [TEMP_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quot_reg[MAG_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            rem_next  = req.dividend[MAG_W +: TEMP_W];
            quot_next = req.dividend[MAG_W-1:0];
            den_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[TEMP_W-1:0] : trial[TEMP_W-1:0];
            quot_next = {quot_reg[MAG_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/duct_damper_balance_step_unit.sv
// duct_damper_balance_step_unit: vent balancing step with iterative divider.
// Depends on ddb_pkg and ddb_div.
//
// Usage:
//   s_* channel: one transfer carries ambient, inside-intake and outside-intake
//   temperatures with their valid flags. m_* channel: one result transfer per
//   input transfer with both openings, both servo angles, write order, status.
//   cfg_* channel: register writes (0 mode, 1 target, 2/3 manual openings);
//   always ready, write only while no item is in flight.
// Path: manual, missing-reading and equal-intake items go from input transfer
//   through S_PREP, S_ANG1 and S_ANG2 to S_OUT; adjusted items also pass S_CALC
//   and S_MOVE, and S_DIV when the move needs the restoring divider. The divider sets the worst case.
// Throughput: one item at a time; s_ready is high only while idle, so an item
//   occupies the block from its input transfer until its result transfer, and
//   the next input transfer comes at the earliest in the cycle after that.
// Stall: the result holds on m_* until m_ready; no input is taken meanwhile.
// Reset: both openings return to fully open inside / closed outside, mode
//   manual, target 320, manual inside 25600, manual outside 0.
`default_nettype none

module duct_damper_balance_step_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [14:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ddb_pkg::temp_t        s_ambient_temp,
    input  wire logic                  s_ambient_valid,
    input  wire ddb_pkg::temp_t        s_inside_temp,
    input  wire logic                  s_inside_valid,
    input  wire ddb_pkg::temp_t        s_outside_temp,
    input  wire logic                  s_outside_valid,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ddb_pkg::open_t             m_inside_opening,
    output ddb_pkg::open_t             m_outside_opening,
    output ddb_pkg::angle_t            m_inside_angle,
    output ddb_pkg::angle_t            m_outside_angle,
    output logic                       m_outside_first,
    output ddb_pkg::status_t           m_status
);
    import ddb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_CALC = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MOVE = 8'b0001_0000,
        S_ANG1 = 8'b0010_0000,
        S_ANG2 = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    function automatic open_t move_open(input open_t v, input mag_t m, input logic up);
        logic signed [16:0] s;
        s = up ? $signed({2'b0, v}) + $signed({5'b0, m})
               : $signed({2'b0, v}) - $signed({5'b0, m});
        if (s < 17'sd0) begin
            return '0;
        end else if (s > $signed({2'b0, FULL_OPEN})) begin
            return FULL_OPEN;
        end else begin
            return s[OPEN_W-1:0];
        end
    endfunction

    function automatic open_t sat_open(input open_t v);
        return (v > FULL_OPEN) ? FULL_OPEN : v;
    endfunction

    state_t  state_reg, state_next;

    logic    mode_reg;
    temp_t   target_reg;
    open_t   man_in_reg;
    open_t   man_out_reg;

    open_t   in_vent_reg, in_vent_next;
    open_t   out_vent_reg, out_vent_next;
    status_t status_reg, status_next;

    temp_t   amb_reg, tin_reg, tout_reg;
    logic    ok_reg;

    logic [TEMP_W-1:0] ad_reg, ad_next;
    logic [TEMP_W-1:0] r_reg, r_next;
    logic              neg_reg, neg_next;
    logic              out_low_reg, out_low_next;
    mag_t              mag_reg, mag_next;

    open_t   a1_reg, o1_reg;
    angle_t  ia_reg, oa_reg;

    logic signed [TEMP_W:0] d_full;
    logic signed [TEMP_W:0] r_full;
    logic [TEMP_W:0]        ad_full;
    logic [TEMP_W:0]        rr_full;
    logic [20:0]            ad_x100;
    logic [16:0]            ad_x5;
    logic [22:0]            p_in;
    logic [22:0]            p_out;
    logic [26:0]            q_in_p;
    logic [26:0]            q_out_p;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ddb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);

    always_comb begin
        d_full  = $signed({target_reg[TEMP_W-1], target_reg}) - $signed({amb_reg[TEMP_W-1], amb_reg});
        r_full  = $signed({tin_reg[TEMP_W-1], tin_reg}) - $signed({tout_reg[TEMP_W-1], tout_reg});
        ad_full = d_full[TEMP_W] ? 15'(-d_full) : 15'(d_full);
        rr_full = r_full[TEMP_W] ? 15'(-r_full) : 15'(r_full);
        ad_x100 = 21'(ad_reg) * 21'(SMALL_FACTOR);
        ad_x5   = 17'(ad_reg) * 17'(BIG_FACTOR);
        p_in    = 23'(in_vent_reg) * 23'(IN_SPAN);
        p_out   = 23'(out_vent_reg) * 23'(OUT_SPAN) + 23'(CEIL_BIAS);
        q_in_p  = 27'(a1_reg) * 27'(RECIP_100);
        q_out_p = 27'(o1_reg) * 27'(RECIP_100);
    end

    always_comb begin
        state_next    = state_reg;
        in_vent_next  = in_vent_reg;
        out_vent_next = out_vent_reg;
        status_next   = status_reg;
        ad_next       = ad_reg;
        r_next        = r_reg;
        neg_next      = neg_reg;
        out_low_next  = out_low_reg;
        mag_next      = mag_reg;
        div_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                ad_next      = ad_full[TEMP_W-1:0];
                r_next       = rr_full[TEMP_W-1:0];
                neg_next     = d_full[TEMP_W];
                out_low_next = r_full > 0;
                if (!mode_reg) begin
                    in_vent_next  = sat_open(man_in_reg);
                    out_vent_next = sat_open(man_out_reg);
                    status_next   = STATUS_MANUAL;
                    state_next    = S_ANG1;
                end else if (!ok_reg) begin
                    in_vent_next  = FULL_OPEN;
                    out_vent_next = '0;
                    status_next   = STATUS_MISSING;
                    state_next    = S_ANG1;
                end else if (r_full == 0) begin
                    status_next   = STATUS_EQUAL;
                    state_next    = S_ANG1;
                end else begin
                    state_next    = S_CALC;
                end
            end
            S_CALC: begin
                if (ad_x100 < 21'(r_reg)) begin
                    mag_next   = '0;
                    state_next = S_MOVE;
                end else if (ad_x5 > 17'(r_reg)) begin
                    mag_next   = BIG_MOVE;
                    state_next = S_MOVE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVD_W'(ad_reg) * DIVD_W'(MOVE_SCALE);
                    div_req.divisor  = r_reg;
                    state_next       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    mag_next   = div_rsp.quot;
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                in_vent_next  = move_open(in_vent_reg, mag_reg, out_low_reg ^ neg_reg);
                out_vent_next = move_open(out_vent_reg, mag_reg, !(out_low_reg ^ neg_reg));
                status_next   = STATUS_ADJUSTED;
                state_next    = S_ANG1;
            end
            S_ANG1: begin
                state_next = S_ANG2;
            end
            S_ANG2: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b0;
            target_reg   <= TARGET_RESET;
            man_in_reg   <= FULL_OPEN;
            man_out_reg  <= '0;
            in_vent_reg  <= FULL_OPEN;
            out_vent_reg <= '0;
            status_reg   <= STATUS_MANUAL;
        end else begin
            state_reg    <= state_next;
            in_vent_reg  <= in_vent_next;
            out_vent_reg <= out_vent_next;
            status_reg   <= status_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg    <= cfg_data[0];
                    REG_TARGET:      target_reg  <= cfg_data[TEMP_W-1:0];
                    REG_MAN_INSIDE:  man_in_reg  <= cfg_data;
                    REG_MAN_OUTSIDE: man_out_reg <= cfg_data;
                    default:         mode_reg    <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            amb_reg  <= s_ambient_temp;
            tin_reg  <= s_inside_temp;
            tout_reg <= s_outside_temp;
            ok_reg   <= s_ambient_valid & s_inside_valid & s_outside_valid;
        end
        ad_reg      <= ad_next;
        r_reg       <= r_next;
        neg_reg     <= neg_next;
        out_low_reg <= out_low_next;
        mag_reg     <= mag_next;
        if (state_reg == S_ANG1) begin
            a1_reg <= p_in[22:8];
            o1_reg <= p_out[22:8];
        end
        if (state_reg == S_ANG2) begin
            ia_reg <= IN_BASE + q_in_p[RECIP_SHIFT +: ANGLE_W];
            oa_reg <= OUT_SPAN - q_out_p[RECIP_SHIFT +: ANGLE_W];
        end
    end

    assign m_inside_opening  = in_vent_reg;
    assign m_outside_opening = out_vent_reg;
    assign m_inside_angle    = ia_reg;
    assign m_outside_angle   = oa_reg;
    assign m_outside_first   = oa_reg > ia_reg;
    assign m_status          = status_reg;

endmodule

`default_nettype wire

// File: rtl/core/ddb_checker.sv
// ddb_checker: port-level assertions for duct_damper_balance_step_unit,
// attached by bind. Depends on ddb_pkg.
`default_nettype none

module ddb_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire ddb_pkg::open_t    m_inside_opening,
    input wire ddb_pkg::open_t    m_outside_opening,
    input wire ddb_pkg::angle_t   m_inside_angle,
    input wire ddb_pkg::angle_t   m_outside_angle,
    input wire logic              m_outside_first,
    input wire ddb_pkg::status_t  m_status
);
    import ddb_pkg::*;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_opening)
            && $stable(m_outside_opening) && $stable(m_status))
        else $error("stalled result changed");

    a_open_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_inside_opening <= FULL_OPEN && m_outside_opening <= FULL_OPEN)
        else $error("opening out of range");

    a_fallback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_MISSING |->
            m_inside_opening == FULL_OPEN && m_outside_opening == '0)
        else $error("missing-reading fallback openings wrong");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_outside_first == (m_outside_angle > m_inside_angle))
        else $error("servo write order inconsistent with angles");

endmodule

bind duct_damper_balance_step_unit ddb_checker u_ddb_checker (.*);

`default_nettype wire
